// ----- src/acfp_pkg.sv -----
// Shared types, constants and codes for the ASCII command frame parser.
package acfp_pkg;

  localparam int PARAM_TEXT_BYTES_DEF = 16;
  localparam int MANT_W = 50;
  localparam logic [MANT_W-1:0] MANTISSA_MAX = 50'd999999999999999;
  localparam logic [3:0] FRAC_MAX = 4'd15;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FRAME_ERR  = 2'd1;
  localparam logic [1:0] ST_OTHER_NODE = 2'd2;

  localparam logic [2:0] REG_HEAD      = 3'd0;
  localparam logic [2:0] REG_TAIL      = 3'd1;
  localparam logic [2:0] REG_BROADCAST = 3'd2;
  localparam logic [2:0] REG_ID_MIN    = 3'd3;
  localparam logic [2:0] REG_ID_MAX    = 3'd4;
  localparam logic [2:0] REG_LOCAL     = 3'd5;

  typedef enum logic [1:0] {PH_SEEK, PH_INSIDE, PH_CLOSED} phase_t;

  typedef enum logic [2:0] {TK_SKIP, TK_ID, TK_CMD, TK_SUB, TK_PARAM, TK_CLOSE} tok_kind_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic [7:0] broadcast_id;
    logic [7:0] id_min;
    logic [7:0] id_max;
    logic [7:0] local_id;
  } cfg_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic       first;
    logic       too_long;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        node_id;
    logic [6:0]        command_letter;
    logic [6:0]        subcommand_letter;
    logic              param_present;
    logic              param_negative;
    logic [MANT_W-1:0] param_mantissa;
    logic [3:0]        param_frac_digits;
  } result_t;

endpackage

// ----- src/acfp_fifo.sv -----
// Small flop-based queue used between the parser stages and at the output.
module acfp_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_rd) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end
endmodule

// ----- src/acfp_front.sv -----
// Front stage: head/tail framing and byte position tagging.
module acfp_front import acfp_pkg::*; #(
  parameter int PARAM_TEXT_BYTES = PARAM_TEXT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  output token_t     tok
);
  localparam int OFF_MAX = PARAM_TEXT_BYTES + 4;
  localparam int OFFW = $clog2(OFF_MAX + 1);

  phase_t          phase, phase_next;
  logic [OFFW-1:0] offset, offset_next;

  always_comb begin
    phase_next  = phase;
    offset_next = offset;
    tok.kind     = TK_SKIP;
    tok.data     = rx_byte;
    tok.last     = buffer_end;
    tok.first    = 1'b0;
    tok.too_long = 1'b0;
    case (phase)
      PH_SEEK: begin
        if (rx_byte == cfg.head_byte) begin
          phase_next  = PH_INSIDE;
          offset_next = '0;
        end
      end
      PH_INSIDE: begin
        if (offset != OFFW'(OFF_MAX)) offset_next = offset + 1'b1;
        if (offset_next >= OFFW'(4) && rx_byte == cfg.tail_byte) begin
          phase_next = PH_CLOSED;
          tok.kind   = TK_CLOSE;
        end else if (offset_next == OFFW'(1)) tok.kind = TK_ID;
        else if (offset_next == OFFW'(2)) tok.kind = TK_CMD;
        else if (offset_next == OFFW'(3)) tok.kind = TK_SUB;
        else tok.kind = TK_PARAM;
        tok.first    = (offset_next == OFFW'(4));
        tok.too_long = (offset_next >= OFFW'(PARAM_TEXT_BYTES + 3));
      end
      default: ;
    endcase
    if (buffer_end) begin
      phase_next  = PH_SEEK;
      offset_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SEEK;
      offset <= '0;
    end else if (take) begin
      phase  <= phase_next;
      offset <= offset_next;
    end
  end
endmodule

// ----- src/acfp_back.sv -----
// Back stage: field capture, decimal accumulation and frame verdict.
module acfp_back import acfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    take,
  input  token_t  tok,
  output result_t res
);
  logic [7:0]        id_b, cmd_b, sub_b;
  logic              closed, any_param, sign_f, digit_f, point_f, stop_f, bad_f;
  logic [MANT_W-1:0] acc;
  logic [3:0]        frac;

  logic [7:0]        id_next, cmd_next, sub_next;
  logic              closed_next, any_next, sign_next, digit_next, point_next;
  logic              stop_next, bad_next;
  logic [MANT_W-1:0] acc_next;
  logic [3:0]        frac_next;
  logic [MANT_W+3:0] prod;
  logic              over, is_digit;

  function automatic logic is_letter(logic [7:0] c);
    return c >= CH_A && c <= CH_Z;
  endfunction

  assign is_digit = tok.data >= CH_0 && tok.data <= CH_9;
  assign prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                + {(MANT_W)'(0), 4'(tok.data - CH_0)};
  assign over = prod > {4'd0, MANTISSA_MAX};

  always_comb begin
    id_next = id_b; cmd_next = cmd_b; sub_next = sub_b;
    closed_next = closed; any_next = any_param; sign_next = sign_f;
    digit_next = digit_f; point_next = point_f; stop_next = stop_f;
    bad_next = bad_f; acc_next = acc; frac_next = frac;
    case (tok.kind)
      TK_ID:    id_next = tok.data;
      TK_CMD:   cmd_next = tok.data;
      TK_SUB:   sub_next = tok.data;
      TK_CLOSE: closed_next = 1'b1;
      TK_PARAM: begin
        any_next = 1'b1;
        if (!bad_f) begin
          if (tok.too_long) bad_next = 1'b1;
          else if (tok.first && tok.data == CH_MINUS) sign_next = 1'b1;
          else if (tok.first && tok.data == CH_PLUS) ;
          else if (is_digit) begin
            digit_next = 1'b1;
            if (!stop_f) begin
              if (!point_f) begin
                if (over) begin
                  acc_next  = MANTISSA_MAX;
                  stop_next = 1'b1;
                end else acc_next = prod[MANT_W-1:0];
              end else if (frac >= FRAC_MAX || over) stop_next = 1'b1;
              else begin
                acc_next  = prod[MANT_W-1:0];
                frac_next = frac + 1'b1;
              end
            end
          end else if (tok.data == CH_POINT && !point_f) point_next = 1'b1;
          else bad_next = 1'b1;
        end
      end
      default: ;
    endcase

    res = '0;
    if (!closed_next) res.status = ST_FRAME_ERR;
    else if (!(id_next == cfg.broadcast_id ||
               (id_next >= cfg.id_min && id_next <= cfg.id_max)))
      res.status = ST_FRAME_ERR;
    else if (!(id_next == cfg.broadcast_id || id_next == cfg.local_id))
      res.status = ST_OTHER_NODE;
    else if (!is_letter(cmd_next) || !is_letter(sub_next)) res.status = ST_FRAME_ERR;
    else if (any_next && (bad_next || !digit_next)) res.status = ST_FRAME_ERR;
    else begin
      res.status            = ST_OK;
      res.node_id           = id_next;
      res.command_letter    = cmd_next[6:0];
      res.subcommand_letter = sub_next[6:0];
      if (any_next) begin
        res.param_present     = 1'b1;
        res.param_negative    = sign_next;
        res.param_mantissa    = acc_next;
        res.param_frac_digits = frac_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && tok.last)) begin
      id_b <= '0; cmd_b <= '0; sub_b <= '0;
      closed <= 1'b0; any_param <= 1'b0; sign_f <= 1'b0; digit_f <= 1'b0;
      point_f <= 1'b0; stop_f <= 1'b0; bad_f <= 1'b0;
      acc <= '0; frac <= '0;
    end else if (take) begin
      id_b <= id_next; cmd_b <= cmd_next; sub_b <= sub_next;
      closed <= closed_next; any_param <= any_next; sign_f <= sign_next;
      digit_f <= digit_next; point_f <= point_next; stop_f <= stop_next;
      bad_f <= bad_next; acc <= acc_next; frac <= frac_next;
    end
  end
endmodule

// ----- src/ascii_command_frame_parser.sv -----
// Top level of the ASCII command frame parser.
// Accepts one byte per cycle, back to back, while full is low; the front stage
// frames and tags each byte, a two-item queue decouples it from the back stage,
// which captures fields, accumulates the decimal parameter (one multiply-by-ten
// add per byte) and gives one result per buffer_end byte into a two-item output
// queue, which drives the output ports; throughput is one byte per cycle while
// the result side keeps popping.
module ascii_command_frame_parser import acfp_pkg::*; #(
  parameter int PARAM_TEXT_BYTES = PARAM_TEXT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte,
  input  logic              buffer_end,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic [7:0]        node_id,
  output logic [6:0]        command_letter,
  output logic [6:0]        subcommand_letter,
  output logic              param_present,
  output logic              param_negative,
  output logic [MANT_W-1:0] param_mantissa,
  output logic [3:0]        param_frac_digits,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  cfg_t    cfg;
  token_t  tok_in, tok_out;
  result_t res_in, res_out;
  logic    take_in, mid_empty, out_full, take_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte    <= 8'd36;
      cfg.tail_byte    <= 8'd10;
      cfg.broadcast_id <= 8'd0;
      cfg.id_min       <= 8'd1;
      cfg.id_max       <= 8'd247;
      cfg.local_id     <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD:      cfg.head_byte    <= cfg_data;
        REG_TAIL:      cfg.tail_byte    <= cfg_data;
        REG_BROADCAST: cfg.broadcast_id <= cfg_data;
        REG_ID_MIN:    cfg.id_min       <= cfg_data;
        REG_ID_MAX:    cfg.id_max       <= cfg_data;
        REG_LOCAL:     cfg.local_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take_in   = push && !full;
  assign take_back = !mid_empty && !out_full;

  acfp_front #(.PARAM_TEXT_BYTES(PARAM_TEXT_BYTES)) u_front (
    .clk, .rst, .cfg, .take(take_in), .rx_byte, .buffer_end, .tok(tok_in)
  );

  acfp_fifo #(.W($bits(token_t)), .DEPTH(2)) u_mid (
    .clk, .rst, .wr(take_in), .wdata(tok_in), .full,
    .rd(take_back), .rdata(tok_out), .empty(mid_empty)
  );

  acfp_back u_back (
    .clk, .rst, .cfg, .take(take_back), .tok(tok_out), .res(res_in)
  );

  acfp_fifo #(.W($bits(result_t)), .DEPTH(2)) u_out (
    .clk, .rst, .wr(take_back && tok_out.last), .wdata(res_in), .full(out_full),
    .rd(pop), .rdata(res_out), .empty
  );

  assign status            = res_out.status;
  assign node_id           = res_out.node_id;
  assign command_letter    = res_out.command_letter;
  assign subcommand_letter = res_out.subcommand_letter;
  assign param_present     = res_out.param_present;
  assign param_negative    = res_out.param_negative;
  assign param_mantissa    = res_out.param_mantissa;
  assign param_frac_digits = res_out.param_frac_digits;

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_OK |-> node_id == 8'd0 && !param_present)
    else $error("non-ok result carries fields");
  a_no_param: assert property (@(posedge clk) disable iff (rst)
    !empty && !param_present |-> param_mantissa == '0 && param_frac_digits == 4'd0)
    else $error("parameter fields without parameter");
  a_mant_max: assert property (@(posedge clk) disable iff (rst)
    !empty |-> param_mantissa <= MANTISSA_MAX)
    else $error("mantissa above limit");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the ASCII command frame parser: queued byte driver, result monitor.
`timescale 1ns / 100ps

module tb_top;
  import acfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint unsigned MANT_CAP = 64'd999999999999999;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } rx_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        rx_byte = '0;
  logic              buffer_end = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        status;
  logic [7:0]        node_id;
  logic [6:0]        command_letter;
  logic [6:0]        subcommand_letter;
  logic              param_present;
  logic              param_negative;
  logic [MANT_W-1:0] param_mantissa;
  logic [3:0]        param_frac_digits;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  ascii_command_frame_parser dut (.*);

  always #5 clk = ~clk;

  rx_item_t   byte_queue[$];
  result_t    frames_due[$];
  cfg_t       regs;
  int         mismatches = 0;
  int         frames_checked = 0;
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  int         tx_gap = 0;
  int         rx_stall = 0;
  logic       took = 1'b0;

  // shadow of the parser's frame state
  phase_t          ph;
  int unsigned     offs;
  logic [7:0]      fid, fcmd, fsub;
  bit              neg, dseen, pseen, stopped, bad;
  longint unsigned acc;
  int unsigned     frac;

  task automatic clear_frame();
    ph = PH_SEEK; offs = 0; fid = 0; fcmd = 0; fsub = 0;
    neg = 0; dseen = 0; pseen = 0; stopped = 0; bad = 0; acc = 0; frac = 0;
  endtask

  function automatic bit is_upper(logic [7:0] c);
    return c >= CH_A && c <= CH_Z;
  endfunction

  task automatic param_char(logic [7:0] c, int unsigned pos);
    longint unsigned d;
    if (bad) return;
    if (pos + 1 >= PARAM_TEXT_BYTES_DEF) begin
      bad = 1;
      return;
    end
    if (pos == 0 && c == CH_MINUS) begin
      neg = 1;
      return;
    end
    if (pos == 0 && c == CH_PLUS) return;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      dseen = 1;
      if (stopped) return;
      if (!pseen) begin
        if (acc > (MANT_CAP - d) / 10) begin
          acc = MANT_CAP;
          stopped = 1;
        end else acc = acc * 10 + d;
      end else if (frac >= FRAC_MAX || acc > (MANT_CAP - d) / 10) begin
        stopped = 1;
      end else begin
        acc = acc * 10 + d;
        frac++;
      end
      return;
    end
    if (c == CH_POINT && !pseen) begin
      pseen = 1;
      return;
    end
    bad = 1;
  endtask

  task automatic frame_byte(logic [7:0] c, logic last);
    result_t r;
    if (ph == PH_SEEK) begin
      if (c == regs.head_byte) begin
        clear_frame();
        ph = PH_INSIDE;
      end
    end else if (ph == PH_INSIDE) begin
      if (offs < 255) offs++;
      if (offs >= 4 && c == regs.tail_byte) ph = PH_CLOSED;
      else if (offs == 1) fid = c;
      else if (offs == 2) fcmd = c;
      else if (offs == 3) fsub = c;
      else param_char(c, offs - 4);
    end
    if (!last) return;
    r = '0;
    if (ph != PH_CLOSED) r.status = ST_FRAME_ERR;
    else if (!(fid == regs.broadcast_id || (fid >= regs.id_min && fid <= regs.id_max)))
      r.status = ST_FRAME_ERR;
    else if (!(fid == regs.broadcast_id || fid == regs.local_id)) r.status = ST_OTHER_NODE;
    else if (!is_upper(fcmd) || !is_upper(fsub)) r.status = ST_FRAME_ERR;
    else if (offs > 4 && (bad || !dseen)) r.status = ST_FRAME_ERR;
    else begin
      r.status = ST_OK;
      r.node_id = fid;
      r.command_letter = fcmd[6:0];
      r.subcommand_letter = fsub[6:0];
      if (offs > 4) begin
        r.param_present = 1'b1;
        r.param_negative = neg;
        r.param_mantissa = acc[MANT_W-1:0];
        r.param_frac_digits = frac[3:0];
      end
    end
    frames_due.push_back(r);
    clear_frame();
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!push || took)) begin
      if (tx_gap > 0) begin
        push <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (byte_queue.size() > 0) begin
        rx_item_t it;
        it = byte_queue.pop_front();
        rx_byte <= it.b;
        buffer_end <= it.e;
        push <= 1'b1;
        tx_gap <= pick_gap();
      end else push <= 1'b0;
    end
    if (!rst) begin
      if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 9) == 0) rx_stall <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    took <= push && !full;
    if (!rst) begin
      if (push && !full) begin
        frame_byte(rx_byte, buffer_end);
        bytes_sent++;
      end
      if (pop && !empty) begin
        got = '{status, node_id, command_letter, subcommand_letter, param_present,
                param_negative, param_mantissa, param_frac_digits};
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: status %0d", got.status);
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st%0d id%0d %0d/%0d p%0d n%0d m%0d f%0d",
                       want.status, want.node_id, want.command_letter,
                       want.subcommand_letter, want.param_present, want.param_negative,
                       want.param_mantissa, want.param_frac_digits);
              $display("          got st%0d id%0d %0d/%0d p%0d n%0d m%0d f%0d",
                       got.status, got.node_id, got.command_letter,
                       got.subcommand_letter, got.param_present, got.param_negative,
                       got.param_mantissa, got.param_frac_digits);
            end
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", frames_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_HEAD:      regs.head_byte = val;
      REG_TAIL:      regs.tail_byte = val;
      REG_BROADCAST: regs.broadcast_id = val;
      REG_ID_MIN:    regs.id_min = val;
      REG_ID_MAX:    regs.id_max = val;
      default:       regs.local_id = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [7:0] h, t, bc, lo, hi, loc);
    write_reg(REG_HEAD, h);
    write_reg(REG_TAIL, t);
    write_reg(REG_BROADCAST, bc);
    write_reg(REG_ID_MIN, lo);
    write_reg(REG_ID_MAX, hi);
    write_reg(REG_LOCAL, loc);
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || push || frames_due.size() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [7:0] junk();
    logic [7:0] v;
    do v = $urandom_range(0, 255); while (v == regs.head_byte);
    return v;
  endfunction

  // one buffer: junk, head, id, letters, parameter text, tail, trailing junk
  task automatic send_frame(logic [7:0] id, c, s, logic [7:0] prm[$], bit close,
                            int pre, int post);
    logic [7:0] buf_q[$];
    rx_item_t it;
    repeat (pre) buf_q.push_back(junk());
    buf_q.push_back(regs.head_byte);
    buf_q.push_back(id);
    buf_q.push_back(c);
    buf_q.push_back(s);
    foreach (prm[i]) buf_q.push_back(prm[i]);
    if (close) buf_q.push_back(regs.tail_byte);
    repeat (post) buf_q.push_back($urandom_range(0, 255));
    foreach (buf_q[i]) begin
      it.b = buf_q[i];
      it.e = (i == buf_q.size() - 1);
      byte_queue.push_back(it);
    end
  endtask

  task automatic send_text(logic [7:0] id, c, s, string txt, bit close);
    logic [7:0] prm[$];
    for (int i = 0; i < txt.len(); i++) prm.push_back(txt[i]);
    send_frame(id, c, s, prm, close, 0, 0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(CH_A, CH_Z);
  endfunction

  task automatic random_frame();
    logic [7:0] prm[$];
    logic [7:0] id;
    int n, k;
    k = $urandom_range(0, 9);
    if (k < 5) id = regs.local_id;
    else if (k < 7) id = regs.broadcast_id;
    else if (k < 8 && regs.id_min <= regs.id_max) id = $urandom_range(regs.id_min, regs.id_max);
    else id = $urandom_range(0, 255);
    if ($urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, 16);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 99);
        if (i == 0 && k < 20) prm.push_back(k < 12 ? CH_MINUS : CH_PLUS);
        else if (k < 85) prm.push_back($urandom_range(CH_0, CH_9));
        else if (k < 95) prm.push_back(CH_POINT);
        else prm.push_back($urandom_range(0, 255));
      end
    end
    send_frame(id, rand_letter(), rand_letter(), prm, $urandom_range(0, 9) != 0,
               $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 4),
               $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
  endtask

  task automatic random_run(int n_bytes);
    int target;
    target = bytes_sent + byte_queue.size() + n_bytes;
    while (bytes_sent + byte_queue.size() < target) begin
      random_frame();
      if (byte_queue.size() > 40) @(negedge clk);
    end
  endtask

  initial begin
    rx_item_t it;
    regs = '{8'd36, 8'd10, 8'd0, 8'd1, 8'd247, 8'd1};
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cases on reset settings
    send_text(8'd1, "A", "B", "", 1);
    send_text(8'd1, "Z", "A", "-12.5", 1);
    send_text(8'd0, "M", "Q", "+7", 1);
    send_text(8'd1, "C", "D", "999999999999999", 1);
    send_text(8'd1, "C", "D", ".000000000000001", 1);
    send_text(8'd1, "C", "D", "1234567890123456", 1);
    send_text(8'd1, "C", "D", "-", 1);
    send_text(8'd1, "C", "D", ".", 1);
    send_text(8'd1, "C", "D", "1.2.3", 1);
    send_text(8'd1, "C", "D", "3-", 1);
    send_frame(8'd1, "C", "D", '{8'h34, 8'h00}, 1, 0, 0);
    send_text(8'd5, "A", "A", "1", 1);
    send_text(8'd247, "A", "A", "", 1);
    send_text(8'd248, "A", "A", "", 1);
    send_text(8'd255, "A", "A", "", 1);
    send_text(8'd1, "@", "A", "", 1);
    send_text(8'd1, "A", "[", "", 1);
    send_text(8'd1, "a", "z", "", 1);
    send_text(8'd1, "A", "B", "42", 0);
    send_text(8'd10, 8'd10, 8'd36, "", 1);
    send_text(8'd1, "A", "B", "$5", 1);
    send_frame(8'd1, "A", "B", '{"1"}, 1, 3, 3);
    it.b = 8'h41; it.e = 1'b1;
    byte_queue.push_back(it);
    drain();
    random_run(190);
    drain();

    set_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255);
    random_run(170);
    drain();
    set_regs(8'd255, 8'd0, 8'd128, 8'd100, 8'd50, 8'd77);
    random_run(170);
    drain();
    set_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 60), $urandom_range(61, 255), $urandom_range(0, 255));
    random_run(190);
    drain();

    $display("%0d bytes sent, %0d results checked over four register settings",
             bytes_sent, frames_checked);
    if (mismatches == 0 && frames_due.size() == 0) $display("TEST PASSED");
    else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, frames_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
